// ===== src/sitda_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds shared constants and the command and status types between controller and datapath.
// No dependencies.
package sitda_pkg;

	localparam int MagBits   = 32;                 // width of the magnitude
	localparam int CntW      = $clog2(MagBits);    // shift counter width
	localparam int NumDigits = 10;                 // decimal digits of a 32-bit magnitude
	localparam int PtrW      = $clog2(NumDigits);  // digit pointer width

	localparam logic [7:0] CharMinus = 8'd45;      // '-'
	localparam logic [7:0] CharZero  = 8'd48;      // '0'

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the input value, clear the BCD register
		logic shift;       // one double-dabble step
		logic find;        // locate the most significant non-zero digit
		logic emit_sign;   // load '-' into the output register
		logic emit_digit;  // load the current digit into the output register
	} sitda_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_done;   // this shift is the final one
		logic neg;         // the captured value is negative
		logic last_digit;  // the digit pointer is at the units digit
	} sitda_status_t;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CONV   = 5'b00010,
		ST_LEAD   = 5'b00100,
		ST_SIGN   = 5'b01000,
		ST_DIGITS = 5'b10000
	} sitda_state_t;

endpackage

// ===== src/sitda_dp.sv =====
// Datapath of the signed integer to decimal ASCII converter: magnitude shift register,
// double-dabble BCD register, digit pointer and output character register.
// Depends on sitda_pkg.
module sitda_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [31:0]      value,
	input  sitda_pkg::sitda_cmd_t   cmd,
	output sitda_pkg::sitda_status_t status,
	output logic [7:0]              char_code,
	output logic                    last
);

	logic [sitda_pkg::MagBits-1:0] mag_q;
	logic [sitda_pkg::CntW-1:0]    cnt_q;
	logic                          neg_q;
	logic [3:0]                    bcd_q [sitda_pkg::NumDigits];
	logic [sitda_pkg::PtrW-1:0]    ptr_q;
	logic [7:0]                    char_q;
	logic                          last_q;

	logic [3:0]                    adj [sitda_pkg::NumDigits];
	logic [sitda_pkg::PtrW-1:0]    msd;
	logic [sitda_pkg::MagBits-1:0] abs_val;

	// Two's complement magnitude; the most negative value yields 2^31 as unsigned.
	assign abs_val = value[31] ? (32'd0 - value) : value;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	// Highest non-zero digit; zero gives the units digit.
	always_comb begin
		msd = '0;
		for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
			if (bcd_q[i] != 4'd0) begin
				msd = sitda_pkg::PtrW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= abs_val;
			neg_q <= value[31];
			for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (cmd.shift) begin
			mag_q    <= {mag_q[sitda_pkg::MagBits-2:0], 1'b0};
			bcd_q[0] <= {adj[0][2:0], mag_q[sitda_pkg::MagBits-1]};
			for (int i = 1; i < sitda_pkg::NumDigits; i++) begin
				bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end
		if (cmd.find) begin
			ptr_q <= msd;
		end else if (cmd.emit_digit) begin
			ptr_q <= ptr_q - 1'b1;
		end
		if (cmd.emit_sign) begin
			char_q <= sitda_pkg::CharMinus;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sitda_pkg::CharZero + {4'd0, bcd_q[ptr_q]};
			last_q <= (ptr_q == '0);
		end
	end

	assign status.conv_done  = (cnt_q == sitda_pkg::CntW'(sitda_pkg::MagBits - 1));
	assign status.neg        = neg_q;
	assign status.last_digit = (ptr_q == '0);
	assign char_code         = char_q;
	assign last              = last_q;

endmodule

// ===== src/sitda_ctrl.sv =====
// Controller of the signed integer to decimal ASCII converter: sequences load, conversion,
// leading-digit search and character emission, and owns both handshakes.
// Depends on sitda_pkg.
module sitda_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  sitda_pkg::sitda_status_t status,
	output sitda_pkg::sitda_cmd_t    cmd
);

	sitda_pkg::sitda_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic emit;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == sitda_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sitda_pkg::ST_CONV;
				end
			end
			sitda_pkg::ST_CONV: begin
				cmd.shift = 1'b1;
				if (status.conv_done) begin
					state_d = sitda_pkg::ST_LEAD;
				end
			end
			sitda_pkg::ST_LEAD: begin
				cmd.find = 1'b1;
				state_d  = status.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGITS;
			end
			sitda_pkg::ST_SIGN: begin
				if (out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = sitda_pkg::ST_DIGITS;
				end
			end
			sitda_pkg::ST_DIGITS: begin
				if (out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit) begin
						state_d = sitda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	assign emit = cmd.emit_sign || cmd.emit_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sitda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("character loaded over an untaken character");

	a_load_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sitda_pkg::ST_CONV))
		else $error("accepted item did not start conversion");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.shift, cmd.find, cmd.emit_sign, cmd.emit_digit}))
		else $error("more than one datapath command at once");

	a_units_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && status.last_digit) |=> (state_q == sitda_pkg::ST_IDLE && out_valid_q))
		else $error("units digit did not end the run");

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Joins the controller (sitda_ctrl) and the datapath (sitda_dp); depends on sitda_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | value (32-bit signed)
//   output  | out_valid / out_ready| char_code (8-bit ASCII), last (end of text)
//
// An item is loaded, shifted through double-dabble (one step per magnitude bit), has its
// leading digit found, and then gives one character per cycle while the output is not stalled.
// Output stalls hold the emission of the next character; a new value is accepted once the
// final character of the previous one has moved into the output register.
// Reset returns the controller to idle and clears out_valid; the character register is not reset.
module signed_int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         char_code,
	output logic               last
);

	// Command and status buses between the controller and the datapath.
	sitda_pkg::sitda_cmd_t    cmd;
	sitda_pkg::sitda_status_t status;

	// The controller owns both handshakes and steps the conversion; every transfer on the
	// output channel carries one character held in the datapath's output register.
	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath forms the magnitude, converts it to ten BCD digits and picks the
	// characters out one at a time, skipping leading zeros.
	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.char_code (char_code),
		.last      (last)
	);

endmodule
